// ===== sv/idll_pkg.sv =====
`default_nettype none

package idll_pkg;

   // command codes
   localparam logic [1:0] CMD_CONNECT = 2'd0;
   localparam logic [1:0] CMD_REMOVE  = 2'd1;
   localparam logic [1:0] CMD_COUNT   = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] first_node;
      logic [7:0] second_node;
   } req_type;

   typedef struct packed {
      logic [8:0] chain_length;
      logic       cycle_found;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/idll_link_ram.sv =====
`default_nettype none

module idll_link_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_valid,
   input  logic [ADDR_W-1:0] wr_link,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_valid,
   output logic [ADDR_W-1:0] rd_link
);

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic              rd_valid_ff;
   logic [ADDR_W-1:0] rd_link_ff;

   // link payload: no reset, a cleared valid bit reads as null
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_link;
      end
      rd_link_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= wr_valid;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_link  = rd_link_ff;

endmodule

`default_nettype wire

// ===== sv/indexed_doubly_linked_list.sv =====
// Doubly linked list over a fixed table of NODE_COUNT nodes.
// Request channel: req_data is taken at a rising edge with start high and busy
// low. Commands: connect first->second, remove first, count chain of first.
// Result channel: one result per count request, shown on rsp_data for exactly
// one cycle with rsp_valid high. The receiver cannot stall; no result is held.
// Work per command, from the accepting edge until busy drops:
//   connect: the table writes happen at the accepting edge; busy stays low
//   remove : one read of both tables, then a splice write, then a clear
//   count  : a walk forward along next links, then back along prev links,
//            one link per cycle; the length reported is at most NODE_COUNT.
//   A count of a node outside the table answers the cycle after acceptance.
// The result strobe is registered together with the drop of busy; a new request
// may be taken in that same cycle.
// Reset (synchronous, active high) nulls every link at once through per-entry
// valid bits and drops busy and rsp_valid.
`default_nettype none

module indexed_doubly_linked_list #(
   parameter int NODE_COUNT = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  idll_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output idll_pkg::rsp_type rsp_data
);

   localparam int DEPTH  = (NODE_COUNT < 256) ? NODE_COUNT : 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(NODE_COUNT + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NODE_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FWD,
      ST_BWD,
      ST_RM_SPLICE,
      ST_RM_CLEAR
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   idll_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              first_ok, second_ok;
   logic [ADDR_W-1:0] first_addr, second_addr;
   logic [31:0]       cnt_wide;

   logic              nx_wr_en, nx_wr_valid, nx_rd_valid;
   logic [ADDR_W-1:0] nx_wr_addr, nx_wr_link, nx_rd_addr, nx_rd_link;
   logic              pv_wr_en, pv_wr_valid, pv_rd_valid;
   logic [ADDR_W-1:0] pv_wr_addr, pv_wr_link, pv_rd_addr, pv_rd_link;

   assign accept      = start && (state_ff == ST_IDLE);
   assign first_ok    = 32'(req_data.first_node) < NODE_COUNT;
   assign second_ok   = 32'(req_data.second_node) < NODE_COUNT;
   assign first_addr  = ADDR_W'(req_data.first_node);
   assign second_addr = ADDR_W'(req_data.second_node);
   assign cnt_wide    = 32'(count_ff);

   idll_link_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_next_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (nx_wr_en),
      .wr_addr  (nx_wr_addr),
      .wr_valid (nx_wr_valid),
      .wr_link  (nx_wr_link),
      .rd_addr  (nx_rd_addr),
      .rd_valid (nx_rd_valid),
      .rd_link  (nx_rd_link)
   );

   idll_link_ram #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_prev_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pv_wr_en),
      .wr_addr  (pv_wr_addr),
      .wr_valid (pv_wr_valid),
      .wr_link  (pv_wr_link),
      .rd_addr  (pv_rd_addr),
      .rd_valid (pv_rd_valid),
      .rd_link  (pv_rd_link)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      start_in     = start_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      nx_rd_addr  = first_addr;
      pv_rd_addr  = first_addr;
      nx_wr_en    = 1'b0;
      nx_wr_addr  = first_addr;
      nx_wr_valid = 1'b0;
      nx_wr_link  = '0;
      pv_wr_en    = 1'b0;
      pv_wr_addr  = first_addr;
      pv_wr_valid = 1'b0;
      pv_wr_link  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  idll_pkg::CMD_CONNECT: begin
                     if (first_ok && second_ok) begin
                        nx_wr_en    = 1'b1;
                        nx_wr_addr  = first_addr;
                        nx_wr_valid = 1'b1;
                        nx_wr_link  = second_addr;
                        pv_wr_en    = 1'b1;
                        pv_wr_addr  = second_addr;
                        pv_wr_valid = 1'b1;
                        pv_wr_link  = first_addr;
                     end
                  end
                  idll_pkg::CMD_REMOVE: begin
                     if (first_ok) begin
                        start_in = first_addr;
                        state_in = ST_RM_SPLICE;
                     end
                  end
                  idll_pkg::CMD_COUNT: begin
                     if (first_ok) begin
                        start_in = first_addr;
                        count_in = CNT_W'(1);
                        state_in = ST_FWD;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FWD: begin
            if (!nx_rd_valid) begin
               pv_rd_addr = start_ff;
               state_in   = ST_BWD;
            end else if (count_ff >= CNT_MAX) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.chain_length = cnt_wide[8:0];
               rsp_data_in.cycle_found  = 1'b1;
               state_in                 = ST_IDLE;
            end else begin
               count_in   = count_ff + CNT_W'(1);
               nx_rd_addr = nx_rd_link;
            end
         end
         ST_BWD: begin
            if (!pv_rd_valid || count_ff >= CNT_MAX) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.chain_length = cnt_wide[8:0];
               rsp_data_in.cycle_found  = pv_rd_valid;
               state_in                 = ST_IDLE;
            end else begin
               count_in   = count_ff + CNT_W'(1);
               pv_rd_addr = pv_rd_link;
            end
         end
         ST_RM_SPLICE: begin
            // read data holds both links of the removed node
            nx_wr_en    = pv_rd_valid;
            nx_wr_addr  = pv_rd_link;
            nx_wr_valid = nx_rd_valid;
            nx_wr_link  = nx_rd_link;
            pv_wr_en    = nx_rd_valid;
            pv_wr_addr  = nx_rd_link;
            pv_wr_valid = pv_rd_valid;
            pv_wr_link  = pv_rd_link;
            state_in    = ST_RM_CLEAR;
         end
         ST_RM_CLEAR: begin
            // after the splice so a self link ends up null
            nx_wr_en   = 1'b1;
            nx_wr_addr = start_ff;
            pv_wr_en   = 1'b1;
            pv_wr_addr = start_ff;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff    <= count_in;
      start_ff    <= start_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_cut_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cycle_found |-> rsp_data.chain_length == 9'(NODE_COUNT))
      else $error("cut walk did not report a saturated length");

   a_connect_no_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.command == idll_pkg::CMD_CONNECT |=> !busy)
      else $error("connect left the block busy");

   a_remove_timing: assert property (@(posedge clock) disable iff (reset)
      accept && first_ok && req_data.command == idll_pkg::CMD_REMOVE
      |=> busy ##1 busy ##1 !busy)
      else $error("remove did not take two cycles");

   a_walk_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FWD || state_ff == ST_BWD) |-> count_ff <= CNT_MAX && count_ff != '0)
      else $error("walk count out of range");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = 256;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   idll_pkg::req_type req_data = '0;
   logic busy;
   logic rsp_valid;
   idll_pkg::rsp_type rsp_data;

   // shadow copy of the link tables
   logic [7:0] next_of [NODES];
   bit next_set [NODES];
   logic [7:0] prev_of [NODES];
   bit prev_set [NODES];

   idll_pkg::rsp_type pending_counts [$];
   int errors = 0;
   int checked = 0;
   int idle_pct = 0;
   int idle_cycles = 0;
   int sent_total = 0;
   int seen_cmd [4];

   indexed_doubly_linked_list #(.NODE_COUNT(NODES)) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_data(req_data),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // Updates the shadow tables for one accepted request; a count queues its answer.
   function automatic void track_request(idll_pkg::req_type r);
      logic [7:0] a, b, n, p, v;
      bit nv, pv, cut;
      int len;
      idll_pkg::rsp_type res;
      a = r.first_node;
      b = r.second_node;
      case (r.command)
         idll_pkg::CMD_CONNECT: begin
            if (int'(a) < NODES && int'(b) < NODES) begin
               next_of[a] = b;
               next_set[a] = 1'b1;
               prev_of[b] = a;
               prev_set[b] = 1'b1;
            end
         end
         idll_pkg::CMD_REMOVE: begin
            if (int'(a) < NODES) begin
               n = next_of[a];
               p = prev_of[a];
               nv = next_set[a];
               pv = prev_set[a];
               if (nv) begin
                  prev_of[n] = p;
                  prev_set[n] = pv;
               end
               if (pv) begin
                  next_of[p] = n;
                  next_set[p] = nv;
               end
               next_set[a] = 1'b0;
               prev_set[a] = 1'b0;
               next_of[a] = '0;
               prev_of[a] = '0;
            end
         end
         idll_pkg::CMD_COUNT: begin
            res = '0;
            if (int'(a) < NODES) begin
               len = 1;
               cut = 1'b0;
               v = a;
               while (next_set[v]) begin
                  if (len >= NODES) begin
                     cut = 1'b1;
                     break;
                  end
                  len++;
                  v = next_of[v];
               end
               v = a;
               while (!cut && prev_set[v]) begin
                  if (len >= NODES) begin
                     cut = 1'b1;
                     break;
                  end
                  len++;
                  v = prev_of[v];
               end
               res.chain_length = len[8:0];
               res.cycle_found = cut;
            end
            pending_counts.push_back(res);
         end
         default: ;
      endcase
   endfunction

   // result check first: a result at an edge always belongs to an earlier request
   always @(posedge clock) begin
      idll_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_counts.size() == 0) begin
               $error("unexpected result: chain_length %0d cycle_found %0d",
                      rsp_data.chain_length, rsp_data.cycle_found);
               errors++;
            end else begin
               want = pending_counts.pop_front();
               if (rsp_data.chain_length !== want.chain_length) begin
                  $error("chain_length: expected %0d, got %0d",
                         want.chain_length, rsp_data.chain_length);
                  errors++;
               end
               if (rsp_data.cycle_found !== want.cycle_found) begin
                  $error("cycle_found: expected %0d, got %0d",
                         want.cycle_found, rsp_data.cycle_found);
                  errors++;
               end
               checked++;
            end
         end
         if (start && !busy)
            track_request(req_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Returns at the edge that takes the request; start stays high for a
   // back-to-back request unless the caller lowers it.
   task automatic send_request(logic [1:0] cmd, logic [7:0] a, logic [7:0] b);
      idll_pkg::req_type r;
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.command = cmd;
      r.first_node = a;
      r.second_node = b;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      seen_cmd[cmd]++;
      sent_total++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_counts.size() != 0 || busy);
      repeat (3) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(idll_pkg::CMD_COUNT, 8'd0, 8'd0);
      send_request(idll_pkg::CMD_COUNT, 8'hFF, 8'hFF);
      send_request(idll_pkg::CMD_CONNECT, 8'd0, 8'hFF);
      send_request(idll_pkg::CMD_COUNT, 8'd0, 8'd0);
      send_request(idll_pkg::CMD_COUNT, 8'hFF, 8'd0);
      // one-node loop: walk saturates
      send_request(idll_pkg::CMD_CONNECT, 8'd7, 8'd7);
      send_request(idll_pkg::CMD_COUNT, 8'd7, 8'd0);
      send_request(idll_pkg::CMD_REMOVE, 8'd7, 8'd0);
      send_request(idll_pkg::CMD_COUNT, 8'd7, 8'd0);
      send_request(idll_pkg::CMD_CONNECT, 8'hAA, 8'h55);
      send_request(idll_pkg::CMD_CONNECT, 8'h55, 8'd12);
      send_request(idll_pkg::CMD_COUNT, 8'h55, 8'd0);
      send_request(idll_pkg::CMD_REMOVE, 8'h55, 8'd0);
      send_request(idll_pkg::CMD_COUNT, 8'hAA, 8'd0);
      send_request(idll_pkg::CMD_COUNT, 8'h55, 8'd0);
      // second connect into 21 leaves 20's next link stale
      send_request(idll_pkg::CMD_CONNECT, 8'd20, 8'd21);
      send_request(idll_pkg::CMD_CONNECT, 8'd22, 8'd21);
      send_request(idll_pkg::CMD_COUNT, 8'd20, 8'd0);
      send_request(idll_pkg::CMD_COUNT, 8'd21, 8'd0);
      send_request(idll_pkg::CMD_REMOVE, 8'd21, 8'd0);
      send_request(idll_pkg::CMD_COUNT, 8'd20, 8'd0);
      send_request(CMD_UNUSED, 8'hFF, 8'hFF);
      send_request(idll_pkg::CMD_REMOVE, 8'hFF, 8'd0);
      send_request(idll_pkg::CMD_REMOVE, 8'd99, 8'd0);
      send_request(idll_pkg::CMD_COUNT, 8'd0, 8'd0);
      wait_drained();
   endtask

   // Mostly clean chains of distinct nodes (removed first, then linked, maybe
   // closed into a ring), counted and trimmed; the rest is random noise.
   task automatic test_random_lists(int items);
      logic [7:0] chain [$];
      bit taken [NODES];
      logic [7:0] pick;
      int len, k, stop_at;
      stop_at = sent_total + items;
      while (sent_total < stop_at) begin
         if ($urandom_range(4) == 0) begin
            send_request(2'($urandom_range(3)), 8'($urandom), 8'($urandom));
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            chain.delete();
            taken = '{default: 1'b0};
            while (chain.size() < len) begin
               pick = 8'($urandom);
               if (!taken[pick]) begin
                  taken[pick] = 1'b1;
                  chain.push_back(pick);
               end
            end
            foreach (chain[i])
               send_request(idll_pkg::CMD_REMOVE, chain[i], 8'($urandom));
            for (k = 1; k < len; k++)
               send_request(idll_pkg::CMD_CONNECT, chain[k-1], chain[k]);
            if ($urandom_range(5) == 0)
               send_request(idll_pkg::CMD_CONNECT, chain[len-1], chain[0]);
            repeat ($urandom_range(1, 3))
               send_request(idll_pkg::CMD_COUNT, chain[$urandom_range(len-1)],
                            8'($urandom));
            repeat ($urandom_range(0, 2))
               send_request(idll_pkg::CMD_REMOVE, chain[$urandom_range(len-1)],
                            8'($urandom));
            send_request(idll_pkg::CMD_COUNT, chain[$urandom_range(len-1)], 8'($urandom));
         end
      end
   endtask

   // every node linked to its successor, then the ends joined into one ring
   task automatic test_full_ring();
      int k;
      for (k = 1; k < NODES; k++)
         send_request(idll_pkg::CMD_CONNECT, 8'(k - 1), 8'(k));
      repeat (3)
         send_request(idll_pkg::CMD_COUNT, 8'($urandom), 8'($urandom));
      send_request(idll_pkg::CMD_CONNECT, 8'(NODES - 1), 8'd0);
      repeat (2)
         send_request(idll_pkg::CMD_COUNT, 8'($urandom), 8'($urandom));
      send_request(idll_pkg::CMD_REMOVE, 8'($urandom), 8'($urandom));
      send_request(idll_pkg::CMD_COUNT, 8'($urandom), 8'($urandom));
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      idle_pct = 10;
      test_random_lists(200);
      wait_drained();
      idle_pct = 64;
      test_random_lists(200);
      wait_drained();
      idle_pct = 0;
      test_full_ring();
      test_random_lists(200);
      wait_drained();
      $display("%0d requests: %0d connect, %0d remove, %0d count, %0d unused",
               sent_total, seen_cmd[idll_pkg::CMD_CONNECT],
               seen_cmd[idll_pkg::CMD_REMOVE], seen_cmd[idll_pkg::CMD_COUNT],
               seen_cmd[CMD_UNUSED]);
      $display("%0d counts checked; sender gaps at 10%% and 64%% and none; %s",
               checked, "chains, rings and a full-table ring");
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
